/* src/rtybs_pkg.sv */
`default_nettype none

package rtybs_pkg;

   localparam int BLOCK_SIZE  = 8;
   localparam int BLK_BITS    = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QLEVEL_W    = 3;

   typedef enum logic [1:0] {
      CSR_GRAY_MODE     = 2'd0,
      CSR_WIDTH_BLOCKS  = 2'd1,
      CSR_HEIGHT_BLOCKS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] chroma_red;
      logic [7:0] chroma_blue;
      logic [7:0] luma;
   } sample_type;

   typedef struct packed {
      logic       emit;
      logic       last_of_image;
      logic [8:0] block_row;
      logic [6:0] block_column;
   } blk_info_type;

   typedef enum logic {
      BK_IDLE,
      BK_SWEEP
   } bk_state_type;

endpackage

`default_nettype wire

/* src/rtybs_fifo.sv */
`default_nettype none

module rtybs_fifo #(
   parameter int WIDTH = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [WIDTH-1:0]                  push_data,
   input  logic                              pop,
   output logic                              pop_valid,
   output logic [WIDTH-1:0]                  pop_data,
   output logic [rtybs_pkg::QLEVEL_W-1:0]    level
);

   logic [WIDTH-1:0]                 slot_ff [0:rtybs_pkg::QUEUE_DEPTH-1];
   logic [rtybs_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rtybs_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rtybs_pkg::QLEVEL_W-1:0]   level_ff, level_in;

   assign pop_valid = (level_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rtybs_pkg::QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + rtybs_pkg::QPTR_W'(pop);
      level_in  = level_ff + rtybs_pkg::QLEVEL_W'(push) - rtybs_pkg::QLEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/rtybs_front.sv */
`default_nettype none

module rtybs_front #(
   parameter int MAX_WIDTH_BLOCKS  = 128,
   parameter int MAX_HEIGHT_BLOCKS = 512
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [9:0]                            csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            red,
   input  logic [7:0]                            green,
   input  logic [7:0]                            blue,
   input  logic [rtybs_pkg::QLEVEL_W-1:0]        q_level,
   output logic                                  q_push,
   output rtybs_pkg::sample_type                 q_sample,
   output rtybs_pkg::blk_info_type               q_info,
   output logic [rtybs_pkg::BLK_BITS-1:0]        q_row,
   output logic [$clog2(MAX_WIDTH_BLOCKS*rtybs_pkg::BLOCK_SIZE)-1:0] q_col
);

   localparam int COL_W   = $clog2(MAX_WIDTH_BLOCKS * rtybs_pkg::BLOCK_SIZE);
   localparam int STRIP_W = (MAX_HEIGHT_BLOCKS > 1) ? $clog2(MAX_HEIGHT_BLOCKS) : 1;
   localparam int RB      = rtybs_pkg::BLK_BITS;

   localparam logic [23:0] K_YR = 24'd19595;
   localparam logic [23:0] K_YG = 24'd38470;
   localparam logic [23:0] K_YB = 24'd7471;
   localparam logic [23:0] K_BR = 24'd11056;
   localparam logic [23:0] K_BG = 24'd21712;
   localparam logic [23:0] K_HF = 24'd32768;
   localparam logic [23:0] K_RG = 24'd27440;
   localparam logic [23:0] K_RB = 24'd5328;
   localparam logic signed [26:0] K_OFS = 27'sd8388608;

   function automatic logic [7:0] clamp_q16(input logic signed [26:0] acc);
      if (acc < 0) begin
         return 8'd0;
      end else if (acc[25:16] > 10'd255) begin
         return 8'hFF;
      end else begin
         return acc[23:16];
      end
   endfunction

   // configuration
   logic        gray_ff, gray_in;
   logic [7:0]  wblk_ff, wblk_in;
   logic [9:0]  hblk_ff, hblk_in;

   // raster position
   logic [COL_W-1:0]   col_ff, col_in;
   logic [RB-1:0]      row_ff, row_in;
   logic [STRIP_W-1:0] strip_ff, strip_in;

   logic [7:0]  eff_w;
   logic [9:0]  eff_h;
   logic        accept;
   rtybs_pkg::blk_info_type cur_info;

   // stage a: products
   logic                    a_valid_ff, a_valid_in;
   logic [23:0]             a_prod_ff [0:8];
   logic [7:0]              a_red_ff;
   logic                    a_gray_ff;
   rtybs_pkg::blk_info_type a_info_ff;
   logic [RB-1:0]           a_row_ff;
   logic [COL_W-1:0]        a_col_ff;

   // stage b: sums and clamp
   logic                    b_valid_ff, b_valid_in;
   rtybs_pkg::sample_type   b_sample_ff, b_sample_in;
   rtybs_pkg::blk_info_type b_info_ff;
   logic [RB-1:0]           b_row_ff;
   logic [COL_W-1:0]        b_col_ff;

   logic signed [26:0] y_acc, cb_acc, cr_acc;

   assign csr_ready  = 1'b1;
   assign req_tready = (32'(q_level) + 32'(a_valid_ff) + 32'(b_valid_ff))
                       < 32'(rtybs_pkg::QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      gray_in = gray_ff;
      wblk_in = wblk_ff;
      hblk_in = hblk_ff;
      if (csr_valid) begin
         case (rtybs_pkg::csr_index_type'(csr_index))
            rtybs_pkg::CSR_GRAY_MODE:     gray_in = csr_data[0];
            rtybs_pkg::CSR_WIDTH_BLOCKS:  wblk_in = csr_data[7:0];
            rtybs_pkg::CSR_HEIGHT_BLOCKS: hblk_in = csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (wblk_ff == 8'd0) begin
         eff_w = 8'd1;
      end else if (32'(wblk_ff) > 32'(MAX_WIDTH_BLOCKS)) begin
         eff_w = 8'(MAX_WIDTH_BLOCKS);
      end else begin
         eff_w = wblk_ff;
      end
      if (hblk_ff == 10'd0) begin
         eff_h = 10'd1;
      end else if (32'(hblk_ff) > 32'(MAX_HEIGHT_BLOCKS)) begin
         eff_h = 10'(MAX_HEIGHT_BLOCKS);
      end else begin
         eff_h = hblk_ff;
      end
   end

   always_comb begin
      cur_info.emit          = (row_ff == RB'(rtybs_pkg::BLOCK_SIZE - 1)) &&
                               (col_ff[RB-1:0] == RB'(rtybs_pkg::BLOCK_SIZE - 1));
      cur_info.last_of_image = (32'(strip_ff) + 32'd1 == 32'(eff_h)) &&
                               (32'(col_ff >> RB) + 32'd1 == 32'(eff_w));
      cur_info.block_row     = 9'(strip_ff);
      cur_info.block_column  = 7'(col_ff >> RB);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      strip_in = strip_ff;
      if (accept) begin
         if (32'(col_ff) + 32'd1 >= 32'({eff_w, 3'b000})) begin
            col_in = '0;
            if (row_ff == RB'(rtybs_pkg::BLOCK_SIZE - 1)) begin
               row_in = '0;
               if (32'(strip_ff) + 32'd1 >= 32'(eff_h)) begin
                  strip_in = '0;
               end else begin
                  strip_in = strip_ff + STRIP_W'(1);
               end
            end else begin
               row_in = row_ff + RB'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign a_valid_in = accept;
   assign b_valid_in = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_ff    <= 1'b0;
         wblk_ff    <= 8'd1;
         hblk_ff    <= 10'd1;
         col_ff     <= '0;
         row_ff     <= '0;
         strip_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         gray_ff    <= gray_in;
         wblk_ff    <= wblk_in;
         hblk_ff    <= hblk_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         strip_ff   <= strip_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_prod_ff[0] <= 24'(red)   * K_YR;
         a_prod_ff[1] <= 24'(green) * K_YG;
         a_prod_ff[2] <= 24'(blue)  * K_YB;
         a_prod_ff[3] <= 24'(red)   * K_BR;
         a_prod_ff[4] <= 24'(green) * K_BG;
         a_prod_ff[5] <= 24'(blue)  * K_HF;
         a_prod_ff[6] <= 24'(red)   * K_HF;
         a_prod_ff[7] <= 24'(green) * K_RG;
         a_prod_ff[8] <= 24'(blue)  * K_RB;
         a_red_ff     <= red;
         a_gray_ff    <= gray_ff;
         a_info_ff    <= cur_info;
         a_row_ff     <= row_ff;
         a_col_ff     <= col_ff;
      end
   end

   always_comb begin
      y_acc  = $signed({3'b000, a_prod_ff[0]}) + $signed({3'b000, a_prod_ff[1]})
             + $signed({3'b000, a_prod_ff[2]});
      cb_acc = K_OFS + $signed({3'b000, a_prod_ff[5]})
             - $signed({3'b000, a_prod_ff[3]}) - $signed({3'b000, a_prod_ff[4]});
      cr_acc = K_OFS + $signed({3'b000, a_prod_ff[6]})
             - $signed({3'b000, a_prod_ff[7]}) - $signed({3'b000, a_prod_ff[8]});
      if (a_gray_ff) begin
         b_sample_in.luma        = a_red_ff;
         b_sample_in.chroma_blue = 8'd128;
         b_sample_in.chroma_red  = 8'd128;
      end else begin
         b_sample_in.luma        = clamp_q16(y_acc);
         b_sample_in.chroma_blue = clamp_q16(cb_acc);
         b_sample_in.chroma_red  = clamp_q16(cr_acc);
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         b_sample_ff <= b_sample_in;
         b_info_ff   <= a_info_ff;
         b_row_ff    <= a_row_ff;
         b_col_ff    <= a_col_ff;
      end
   end

   assign q_push   = b_valid_ff;
   assign q_sample = b_sample_ff;
   assign q_info   = b_info_ff;
   assign q_row    = b_row_ff;
   assign q_col    = b_col_ff;

endmodule

`default_nettype wire

/* src/rtybs_back.sv */
`default_nettype none

module rtybs_back #(
   parameter int MAX_WIDTH_BLOCKS = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   output logic                                  q_pop,
   input  rtybs_pkg::sample_type                 q_sample,
   input  rtybs_pkg::blk_info_type               q_info,
   input  logic [rtybs_pkg::BLK_BITS-1:0]        q_row,
   input  logic [$clog2(MAX_WIDTH_BLOCKS*rtybs_pkg::BLOCK_SIZE)-1:0] q_col,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rtybs_pkg::sample_type                 rsp_sample,
   output logic [6:0]                            rsp_block_column,
   output logic [8:0]                            rsp_block_row,
   output logic [rtybs_pkg::BLK_BITS-1:0]        rsp_row,
   output logic [rtybs_pkg::BLK_BITS-1:0]        rsp_col,
   output logic                                  rsp_last_blk,
   output logic                                  rsp_last_img
);

   localparam int COL_W  = $clog2(MAX_WIDTH_BLOCKS * rtybs_pkg::BLOCK_SIZE);
   localparam int RB     = rtybs_pkg::BLK_BITS;
   localparam int ADDR_W = COL_W + RB;
   localparam int CNT_W  = 2 * RB;

   rtybs_pkg::sample_type mem [0:(1 << ADDR_W)-1];

   rtybs_pkg::bk_state_type state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [COL_W-1:0]        sweep_base_ff;
   rtybs_pkg::blk_info_type sweep_info_ff;
   logic                    issue;
   logic                    start;
   logic [ADDR_W-1:0]       rd_addr;

   // read stage
   logic                    r_valid_ff, r_valid_in;
   rtybs_pkg::sample_type   r_data_ff;
   logic [CNT_W-1:0]        r_cnt_ff;
   rtybs_pkg::blk_info_type r_info_ff;
   logic                    r_free;

   // output stage
   logic                    o_valid_ff, o_valid_in;
   rtybs_pkg::sample_type   o_sample_ff;
   logic [CNT_W-1:0]        o_cnt_ff;
   rtybs_pkg::blk_info_type o_info_ff;
   logic                    o_load;

   assign o_load = r_valid_ff && (!o_valid_ff || rsp_ready);
   assign r_free = !r_valid_ff || o_load;

   always_comb begin
      q_pop = 1'b0;
      issue = 1'b0;
      case (state_ff)
         rtybs_pkg::BK_IDLE: begin
            q_pop = q_valid;
         end
         rtybs_pkg::BK_SWEEP: begin
            // pixels of other blocks may be stored while this one drains
            q_pop = q_valid && !q_info.emit &&
                    ((q_col >> RB) != (sweep_base_ff >> RB));
            issue = r_free;
         end
         default: ;
      endcase
   end

   assign start = (state_ff == rtybs_pkg::BK_IDLE) && q_pop && q_info.emit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtybs_pkg::BK_IDLE: begin
            if (start) begin
               state_in = rtybs_pkg::BK_SWEEP;
            end
         end
         rtybs_pkg::BK_SWEEP: begin
            if (issue && (&cnt_ff)) begin
               state_in = rtybs_pkg::BK_IDLE;
            end
         end
         default: state_in = rtybs_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cnt_in     = issue ? cnt_ff + CNT_W'(1) : cnt_ff;
      r_valid_in = issue ? 1'b1 : (o_load ? 1'b0 : r_valid_ff);
      o_valid_in = o_load ? 1'b1 : (rsp_ready ? 1'b0 : o_valid_ff);
      rd_addr    = {cnt_ff[CNT_W-1:RB], sweep_base_ff | COL_W'(cnt_ff[RB-1:0])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rtybs_pkg::BK_IDLE;
         cnt_ff     <= '0;
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         r_valid_ff <= r_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         mem[{q_row, q_col}] <= q_sample;
      end
      if (issue) begin
         r_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sweep_base_ff <= (q_col >> RB) << RB;
         sweep_info_ff <= q_info;
      end
      if (issue) begin
         r_cnt_ff  <= cnt_ff;
         r_info_ff <= sweep_info_ff;
      end
      if (o_load) begin
         o_sample_ff <= r_data_ff;
         o_cnt_ff    <= r_cnt_ff;
         o_info_ff   <= r_info_ff;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_sample       = o_sample_ff;
   assign rsp_block_column = o_info_ff.block_column;
   assign rsp_block_row    = o_info_ff.block_row;
   assign rsp_row          = o_cnt_ff[CNT_W-1:RB];
   assign rsp_col          = o_cnt_ff[RB-1:0];
   assign rsp_last_blk     = &o_cnt_ff;
   assign rsp_last_img     = (&o_cnt_ff) && o_info_ff.last_of_image;

endmodule

`default_nettype wire

/* src/rgb_to_ycbcr_block_splitter.sv */
// RGB pixels enter in raster order and are converted to YCbCr (Q16 JPEG
// coefficients, or Y=R, Cb=Cr=128 in gray mode), then stored in an eight-row
// line store of 8*MAX_WIDTH_BLOCKS words per row. The pixel that closes an
// 8x8 block releases that block's 64 words in row-major order, tlast on the
// 64th, tuser on the 64th word of the image's last block. Outside the last
// row of a strip one pixel is taken per cycle unless the output stalls;
// in that row each block's 64 words are read through the single read port
// of the store, and the pixel closing the next block waits until that
// readout is done. A 4-entry queue separates conversion from the store,
// so either side may stall alone. The store is not cleared after reset;
// the user must write the registers over the csr port (always ready) only
// while no image is in flight; the block itself does not enforce this.
`default_nettype none

module rgb_to_ycbcr_block_splitter #(
   parameter int MAX_WIDTH_BLOCKS  = 128,
   parameter int MAX_HEIGHT_BLOCKS = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // luma, chroma_blue, chroma_red, block_column,
                                    // block_row, row_in_block, col_in_block, zero pad
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // last_of_image
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH_BLOCKS * rtybs_pkg::BLOCK_SIZE);
   localparam int RB      = rtybs_pkg::BLK_BITS;
   localparam int ENTRY_W = COL_W + RB + $bits(rtybs_pkg::blk_info_type)
                            + $bits(rtybs_pkg::sample_type);

   logic                            f_push;
   rtybs_pkg::sample_type           f_sample;
   rtybs_pkg::blk_info_type         f_info;
   logic [RB-1:0]                   f_row;
   logic [COL_W-1:0]                f_col;
   logic [rtybs_pkg::QLEVEL_W-1:0]  q_level;

   logic                            q_valid;
   logic                            q_pop;
   logic [ENTRY_W-1:0]              q_data;
   rtybs_pkg::sample_type           q_sample;
   rtybs_pkg::blk_info_type         q_info;
   logic [RB-1:0]                   q_row;
   logic [COL_W-1:0]                q_col;

   rtybs_pkg::sample_type           o_sample;
   logic [6:0]                      o_block_column;
   logic [8:0]                      o_block_row;
   logic [RB-1:0]                   o_row;
   logic [RB-1:0]                   o_col;

   rtybs_front #(
      .MAX_WIDTH_BLOCKS  (MAX_WIDTH_BLOCKS),
      .MAX_HEIGHT_BLOCKS (MAX_HEIGHT_BLOCKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .red        (req_tdata[7:0]),
      .green      (req_tdata[15:8]),
      .blue       (req_tdata[23:16]),
      .q_level    (q_level),
      .q_push     (f_push),
      .q_sample   (f_sample),
      .q_info     (f_info),
      .q_row      (f_row),
      .q_col      (f_col)
   );

   rtybs_fifo #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_col, f_row, f_info, f_sample}),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .level     (q_level)
   );

   assign {q_col, q_row, q_info, q_sample} = q_data;

   rtybs_back #(
      .MAX_WIDTH_BLOCKS (MAX_WIDTH_BLOCKS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_sample         (q_sample),
      .q_info           (q_info),
      .q_row            (q_row),
      .q_col            (q_col),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_sample       (o_sample),
      .rsp_block_column (o_block_column),
      .rsp_block_row    (o_block_row),
      .rsp_row          (o_row),
      .rsp_col          (o_col),
      .rsp_last_blk     (rsp_tlast),
      .rsp_last_img     (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, o_col, o_row, o_block_row, o_block_column,
                       o_sample.chroma_red, o_sample.chroma_blue, o_sample.luma};

endmodule

`default_nettype wire
